### hw/rtl/incremental_deadlock_detector_top_assert.svh
// Assertion macros for the incremental deadlock detector.
// Used by incremental_deadlock_detector_top; no other dependencies.
`ifndef INCREMENTAL_DEADLOCK_DETECTOR_TOP_ASSERT_SVH
`define INCREMENTAL_DEADLOCK_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define IDD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define IDD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IDD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define IDD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/idd_pkg.sv
// Shared constants for the incremental deadlock detector.
// No dependencies.
`default_nettype none
package idd_pkg;
  localparam int NUM_PROCS_DEF  = 16;
  localparam int NUM_RES_DEF    = 16;
  localparam int MULT_WIDTH_DEF = 4;
  localparam int ID_W           = 4;
  localparam int EDGE_W         = 16;
  localparam int MAX_OUT        = 16;
  localparam logic ACT_REQUEST  = 1'b0;
  localparam logic ACT_ASSIGN   = 1'b1;
endpackage
`default_nettype wire

### hw/rtl/idd_if.sv
// Channel interfaces for edges in and results out.
// Depends on idd_pkg.
`default_nettype none
interface idd_edge_if import idd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [ID_W-1:0] process_id;
  logic [ID_W-1:0] resource_id;
  modport source (output valid, action, process_id, resource_id, input ready);
  modport sink (input valid, action, process_id, resource_id, output ready);
endinterface

interface idd_result_if import idd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              deadlock;
  logic [ID_W-1:0]   blocked_process;
  logic [EDGE_W-1:0] edge_num;
  logic              count_overflow;
  logic              last;
  modport source (output valid, deadlock, blocked_process, edge_num, count_overflow, last,
                  input ready);
  modport sink (input valid, deadlock, blocked_process, edge_num, count_overflow, last,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/incremental_deadlock_detector_top.sv
// Per edge: it is taken and, if in range, its counter read and updated, then
// k sweeps over the NUM_PROCS + NUM_RES nodes, one node per cycle, through the
// shared removal check (k <= NUM_PROCS + NUM_RES + 1), then a report scan over up to
// NUM_PROCS processes; one edge at a time, the next one taken in the cycle
// after the last result is registered. After a deadlock latches an edge
// goes straight to the scan. Reset (rst, synchronous) clears the graph at once.
// Depends on idd_pkg, idd_if and incremental_deadlock_detector_top_assert.svh.
`default_nettype none
`include "incremental_deadlock_detector_top_assert.svh"
module incremental_deadlock_detector_top import idd_pkg::*; #(
  parameter int NUM_PROCS  = NUM_PROCS_DEF,
  parameter int NUM_RES    = NUM_RES_DEF,
  parameter int MULT_WIDTH = MULT_WIDTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  idd_edge_if.sink      edges,
  idd_result_if.source  results
);
  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
  localparam int NN = NUM_PROCS + NUM_RES;
  localparam int NW = $clog2(NN);
  localparam int AW = 1 + PW + RW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [MULT_WIDTH-1:0] MULT_MAX = {MULT_WIDTH{1'b1}};
  localparam logic [NW-1:0] LAST_NODE = NW'(NN - 1);
  localparam logic [NW-1:0] FIRST_RES = NW'(NUM_PROCS);
  localparam logic [PW-1:0] LAST_PROC = PW'(NUM_PROCS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPD    = 3'd2;
  localparam logic [2:0] S_PEEL   = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  logic [2:0] state;

  logic [NUM_PROCS-1:0][NUM_RES-1:0] req_nz;
  logic [NUM_RES-1:0][NUM_PROCS-1:0] hold_nz;
  logic [MULT_WIDTH-1:0] mult_mem [MEM_DEPTH];
  logic [MULT_WIDTH-1:0] rd_data;

  logic              act;
  logic [PW-1:0]     pid;
  logic [RW-1:0]     rid;
  logic [EDGE_W-1:0] edge_counter;
  logic [EDGE_W-1:0] idx;
  logic              ovf;
  logic              latched;
  logic [EDGE_W-1:0] deadlock_edge;
  logic [NUM_PROCS-1:0] left_lat;

  logic [NUM_PROCS-1:0] pgone;
  logic [NUM_RES-1:0]   rgone;
  logic [NW-1:0]        ptr;
  logic                 changed;

  logic [NUM_PROCS-1:0] rep_left;
  logic [PW-1:0]        rep_ptr;
  logic [ID_W-1:0]      rep_k;

  logic              out_valid;
  logic              out_deadlock;
  logic [ID_W-1:0]   out_proc;
  logic [EDGE_W-1:0] out_edge;
  logic              out_ovf;
  logic              out_last;

  logic              in_range;
  logic [AW-1:0]     addr;
  logic              is_proc;
  logic [PW-1:0]     node_p;
  logic [RW-1:0]     node_r;
  logic              rm;
  logic [NUM_PROCS-1:0] above;
  logic              rest;
  logic              out_free;
  logic [MULT_WIDTH-1:0] cur;

  assign in_range = (32'(edges.process_id) < NUM_PROCS) && (32'(edges.resource_id) < NUM_RES);
  assign addr     = {act, pid, rid};
  assign is_proc  = ptr < FIRST_RES;
  assign node_p   = ptr[PW-1:0];
  assign node_r   = RW'(ptr - FIRST_RES);
  assign out_free = !out_valid || results.ready;
  assign cur      = (act == ACT_REQUEST ? req_nz[pid][rid] : hold_nz[rid][pid]) ? rd_data
                                                                                  : '0;

  always_comb begin
    if (is_proc) begin
      rm = !pgone[node_p] && ((req_nz[node_p] & ~rgone) == '0);
    end else begin
      rm = !rgone[node_r] && ((hold_nz[node_r] & ~pgone) == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PROCS; i++) begin
      above[i] = (PW'(i) > rep_ptr);
    end
    rest = |(rep_left & above);
  end

  assign edges.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= mult_mem[addr];
    end
    if (state == S_UPD && cur != MULT_MAX) begin
      mult_mem[addr] <= cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      req_nz        <= '0;
      hold_nz       <= '0;
      edge_counter  <= '0;
      latched       <= 1'b0;
      deadlock_edge <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (edges.valid) begin
            act          <= edges.action;
            pid          <= PW'(edges.process_id);
            rid          <= RW'(edges.resource_id);
            idx          <= edge_counter;
            edge_counter <= edge_counter + 1'b1;
            ovf          <= 1'b0;
            pgone        <= '0;
            rgone        <= '0;
            ptr          <= '0;
            changed      <= 1'b0;
            rep_ptr      <= '0;
            rep_k        <= '0;
            if (latched) begin
              rep_left <= left_lat;
              state    <= S_REPORT;
            end else if (in_range) begin
              state <= S_READ;
            end else begin
              state <= S_PEEL;
            end
          end
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (cur == MULT_MAX) begin
            ovf <= 1'b1;
          end
          if (act == ACT_REQUEST) begin
            req_nz[pid][rid] <= 1'b1;
          end else begin
            hold_nz[rid][pid] <= 1'b1;
          end
          state <= S_PEEL;
        end
        S_PEEL: begin
          if (rm) begin
            if (is_proc) begin
              pgone[node_p] <= 1'b1;
            end else begin
              rgone[node_r] <= 1'b1;
            end
          end
          if (ptr == LAST_NODE) begin
            if (changed || rm) begin
              ptr     <= '0;
              changed <= 1'b0;
            end else begin
              rep_left <= ~pgone;
              if (pgone != '1) begin
                latched       <= 1'b1;
                deadlock_edge <= idx;
                left_lat      <= ~pgone;
              end
              state <= S_REPORT;
            end
          end else begin
            ptr     <= ptr + 1'b1;
            changed <= changed || rm;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            if (rep_left == '0) begin
              out_valid    <= 1'b1;
              out_deadlock <= 1'b0;
              out_proc     <= '0;
              out_edge     <= idx;
              out_ovf      <= ovf;
              out_last     <= 1'b1;
              state        <= S_IDLE;
            end else if (rep_left[rep_ptr]) begin
              out_valid    <= 1'b1;
              out_deadlock <= 1'b1;
              out_proc     <= ID_W'(rep_ptr);
              out_edge     <= deadlock_edge;
              out_ovf      <= ovf;
              out_last     <= !rest || (rep_k == ID_W'(MAX_OUT - 1));
              rep_k        <= rep_k + 1'b1;
              rep_ptr      <= rep_ptr + 1'b1;
              if (!rest || (rep_k == ID_W'(MAX_OUT - 1)) || rep_ptr == LAST_PROC) begin
                state <= S_IDLE;
              end
            end else begin
              rep_ptr <= rep_ptr + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid           = out_valid;
  assign results.deadlock        = out_deadlock;
  assign results.blocked_process = out_proc;
  assign results.edge_num        = out_edge;
  assign results.count_overflow  = out_ovf;
  assign results.last            = out_last;

  `IDD_ASSERT_IMPLY(a_nodl_single, clk, rst, out_valid && !out_deadlock, out_last && out_proc == '0)
  `IDD_ASSERT_IMPLY(a_latch_nonempty, clk, rst, latched, left_lat != '0)
  `IDD_ASSERT_NEXT(a_busy_after_take, clk, rst, edges.valid && edges.ready, !edges.ready)
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for incremental_deadlock_detector_top: directed and random edges in, blocked-process
// reports out, each compared against an in-bench graph-peeling predictor.
// Depends on idd_pkg, idd_if and the detector RTL.
module tb_top;
  import idd_pkg::*;

  typedef struct packed {
    logic              deadlock;
    logic [ID_W-1:0]   blocked_process;
    logic [EDGE_W-1:0] edge_num;
    logic              count_overflow;
    logic              last;
  } report_t;

  logic clk;
  logic rst;
  idd_edge_if   edges ();
  idd_result_if results ();

  incremental_deadlock_detector_top uut (
    .clk(clk), .rst(rst), .edges(edges), .results(results)
  );

  logic [MULT_WIDTH_DEF-1:0] req_count  [NUM_PROCS_DEF][NUM_RES_DEF];
  logic [MULT_WIDTH_DEF-1:0] hold_count [NUM_RES_DEF][NUM_PROCS_DEF];
  logic [EDGE_W-1:0]         next_edge;
  logic                      latched;
  logic [EDGE_W-1:0]         latched_edge;
  logic [NUM_PROCS_DEF-1:0]  latched_stuck;
  report_t                   pending_reports[$];
  int                        mismatches;
  bit                        no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("** incremental_deadlock_detector_top: FAILED **");
    $finish;
  end

  function automatic logic [NUM_PROCS_DEF-1:0] stuck_processes();
    bit [NUM_PROCS_DEF-1:0] pgone;
    bit [NUM_RES_DEF-1:0]   rgone;
    bit changed;
    bit ok;
    pgone = '0;
    rgone = '0;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int p = 0; p < NUM_PROCS_DEF; p++) begin
        if (!pgone[p]) begin
          ok = 1'b1;
          for (int r = 0; r < NUM_RES_DEF; r++)
            if (req_count[p][r] != 0 && !rgone[r]) ok = 1'b0;
          if (ok) begin
            pgone[p] = 1'b1;
            changed = 1'b1;
          end
        end
      end
      for (int r = 0; r < NUM_RES_DEF; r++) begin
        if (!rgone[r]) begin
          ok = 1'b1;
          for (int p = 0; p < NUM_PROCS_DEF; p++)
            if (hold_count[r][p] != 0 && !pgone[p]) ok = 1'b0;
          if (ok) begin
            rgone[r] = 1'b1;
            changed = 1'b1;
          end
        end
      end
    end
    return ~pgone;
  endfunction

  task automatic predict_reports(input logic act, input logic [ID_W-1:0] pid,
                                 input logic [ID_W-1:0] rid);
    logic [EDGE_W-1:0]        idx;
    logic                     ovf;
    logic [NUM_PROCS_DEF-1:0] stuck;
    int                       total;
    int                       k;
    report_t                  rep;
    idx = next_edge;
    next_edge = next_edge + 1'b1;
    ovf = 1'b0;
    if (!latched) begin
      if (act == ACT_REQUEST) begin
        if (&req_count[pid][rid]) ovf = 1'b1;
        else req_count[pid][rid] = req_count[pid][rid] + 1'b1;
      end else begin
        if (&hold_count[rid][pid]) ovf = 1'b1;
        else hold_count[rid][pid] = hold_count[rid][pid] + 1'b1;
      end
      stuck = stuck_processes();
    end else begin
      stuck = latched_stuck;
    end
    if (stuck == '0) begin
      rep = '{deadlock: 1'b0, blocked_process: '0, edge_num: idx,
              count_overflow: ovf, last: 1'b1};
      pending_reports.insert(pending_reports.size(), rep);
    end else begin
      if (!latched) begin
        latched = 1'b1;
        latched_edge = idx;
        latched_stuck = stuck;
      end else begin
        ovf = 1'b0;
      end
      total = $countones(stuck);
      if (total > MAX_OUT) total = MAX_OUT;
      k = 0;
      for (int p = 0; p < NUM_PROCS_DEF && k < total; p++) begin
        if (stuck[p]) begin
          rep = '{deadlock: 1'b1, blocked_process: p[ID_W-1:0], edge_num: latched_edge,
                  count_overflow: ovf, last: (k == total - 1)};
          pending_reports.insert(pending_reports.size(), rep);
          k++;
        end
      end
    end
  endtask

  task automatic send_edge(input logic act, input logic [ID_W-1:0] pid,
                           input logic [ID_W-1:0] rid);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      edges.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edges.valid       <= 1'b1;
    edges.action      <= act;
    edges.process_id  <= pid;
    edges.resource_id <= rid;
    @(posedge clk);
    while (!edges.ready) @(posedge clk);
    predict_reports(act, pid, rid);
  endtask

  task automatic wait_drained();
    edges.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // acyclic by construction: requests go to resource >= process, holds to process > resource
  task automatic send_acyclic_edge();
    logic [ID_W-1:0] pid;
    logic [ID_W-1:0] rid;
    if ($urandom_range(0, 1) == 0) begin
      pid = ID_W'($urandom_range(0, 15));
      rid = ID_W'($urandom_range(pid, 15));
      send_edge(ACT_REQUEST, pid, rid);
    end else begin
      rid = ID_W'($urandom_range(0, 14));
      pid = ID_W'($urandom_range(rid + 1, 15));
      send_edge(ACT_ASSIGN, pid, rid);
    end
  endtask

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst && results.valid && results.ready) begin
      got = '{results.deadlock, results.blocked_process, results.edge_num,
              results.count_overflow, results.last};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    results.ready <= 1'b0;
    @(negedge rst);
    forever begin
      results.ready <= 1'b1;
      @(posedge clk);
      while (!(results.valid && results.ready)) @(posedge clk);
      wait_cycles = no_idle ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        results.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
    end
  end

  task automatic test_single_edges();
    send_edge(ACT_REQUEST, 4'd0, 4'd0);
    send_edge(ACT_REQUEST, 4'd0, 4'd15);
    send_edge(ACT_REQUEST, 4'd15, 4'd15);
    send_edge(ACT_ASSIGN, 4'd15, 4'd0);
    send_edge(ACT_ASSIGN, 4'd15, 4'd14);
  endtask

  task automatic test_saturation();
    repeat (17) send_edge(ACT_REQUEST, 4'd3, 4'd5);
    no_idle = 1'b1;
    repeat (17) send_edge(ACT_ASSIGN, 4'd6, 4'd5);
    no_idle = 1'b0;
  endtask

  task automatic test_chain();
    for (int i = 0; i < 16; i++) begin
      send_edge(ACT_REQUEST, i[ID_W-1:0], i[ID_W-1:0]);
      if (i < 15) send_edge(ACT_ASSIGN, i[ID_W-1:0] + 1'b1, i[ID_W-1:0]);
    end
  endtask

  task automatic test_random_acyclic();
    for (int i = 0; i < 170; i++) begin
      if (i == 60) wait_drained();
      no_idle = (i >= 100 && i < 130);
      send_acyclic_edge();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_close_cycle();
    send_edge(ACT_ASSIGN, 4'd0, 4'd15);
  endtask

  task automatic test_latched_noise();
    repeat (20)
      send_edge(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 15)),
                ID_W'($urandom_range(0, 15)));
  endtask

  initial begin
    rst = 1'b1;
    edges.valid <= 1'b0;
    edges.action <= ACT_REQUEST;
    edges.process_id <= '0;
    edges.resource_id <= '0;
    for (int p = 0; p < NUM_PROCS_DEF; p++)
      for (int r = 0; r < NUM_RES_DEF; r++) begin
        req_count[p][r] = '0;
        hold_count[r][p] = '0;
      end
    next_edge = '0;
    latched = 1'b0;
    latched_edge = '0;
    latched_stuck = '0;
    mismatches = 0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_edges();
    test_saturation();
    test_chain();
    test_random_acyclic();
    test_close_cycle();
    test_latched_noise();
    wait_drained();
    repeat (1200) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("** incremental_deadlock_detector_top: PASSED **");
    end else begin
      $display("** incremental_deadlock_detector_top: FAILED **");
    end
    $finish;
  end
endmodule
